/* rtl/core/itrds_pkg.sv */
`default_nettype none

package itrds_pkg;

  // Register capacity of the alphabet and the largest radix accepted
  localparam int NumSyms   = 16;
  localparam int MaxBase   = 16;
  localparam int MinBase   = 2;
  localparam int SymW      = 8;
  localparam int AlphaW    = NumSyms * SymW;
  localparam int BaseW     = 5;
  localparam int RemW      = 4;
  localparam int ValueW    = 32;

  // Divider works one 8-bit slice of the dividend per cycle
  localparam int SliceW        = 8;
  localparam int StepsPerDigit = ValueW / SliceW;
  localparam int StepW         = $clog2(StepsPerDigit);

  localparam int MaxDigits = ValueW;
  localparam int DigIdxW   = $clog2(MaxDigits);
  localparam int DigCntW   = DigIdxW + 1;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  localparam logic [SymW-1:0] PlusChar  = 8'h2B;
  localparam logic [SymW-1:0] MinusChar = 8'h2D;
  localparam logic [SymW-1:0] SymLow    = 8'd32;
  localparam logic [SymW-1:0] SymHigh   = 8'd126;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBaseLen   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlphaLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAlphaHigh = 2'd2;

  typedef struct packed {
    logic [BaseW-1:0]  base;
    logic [AlphaW-1:0] alphabet;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } q_entry_t;

  // Eight restoring-division steps on one slice; returns {remainder, quotient slice}
  function automatic logic [RemW+SliceW-1:0] div_slice(logic [RemW-1:0]   rem,
                                                       logic [SliceW-1:0] slice,
                                                       logic [BaseW-1:0]  base);
    logic [RemW:0]     t;
    logic [RemW-1:0]   r;
    logic [SliceW-1:0] q;
    r = rem;
    q = '0;
    for (int k = SliceW - 1; k >= 0; k--) begin
      t = {r, slice[k]};
      if (t >= base) begin
        t    = t - base;
        q[k] = 1'b1;
      end
      r = t[RemW-1:0];
    end
    return {r, q};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/integer_to_radix_digit_stream.sv */
// Integer to radix text converter.
// Input channel (in_valid_i/in_ready_o, value_i): one signed 32-bit value per item.
// Output channel (out_valid_o/out_ready_i, character_o, last_o): one character per
// item, most significant digit first, '-' first for negative values, last_o set on
// the final character of each value. An invalid alphabet swallows values silently.
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is high;
// 0 radix (5 bits), 1 symbols 0..7, 2 symbols 8..15 (symbol 0 in the low byte).
// Write only while the block is idle.
// Timing: an item passes through the input stage and the queue, then the divider
// (one 8-bit slice of the dividend per cycle through the shared divider), then one
// character per cycle while the receiver is ready, sign included. The next value
// enters the divider only after the last character of the current one. The front
// holds up to three values ahead.
// Reset clears the registers (radix 0: no output until configured) and drops all
// items in flight. When the receiver stalls, the current character is held in the
// output register and the converter waits; the input side keeps taking items
// until its queue fills.
`default_nettype none

module integer_to_radix_digit_stream import itrds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              character_o,
  output logic                    last_o
);

  cfg_t     cfg;
  logic     push;
  q_entry_t push_data;
  logic     full;
  logic     pop;
  logic     q_valid;
  q_entry_t q_data;

  itrds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .cfg_o       (cfg),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  itrds_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  itrds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (q_valid),
    .data_i      (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

/* rtl/core/itrds_fifo.sv */
`default_nettype none

module itrds_fifo import itrds_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output q_entry_t      pop_data_o
);

  q_entry_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (cnt_q == QCntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/itrds_front.sv */
`default_nettype none

module itrds_front import itrds_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ValueW-1:0]  value_i,
  output cfg_t                    cfg_o,
  output logic                    push_o,
  output q_entry_t                push_data_o,
  input  wire logic               full_i
);

  logic [BaseW-1:0]  base_q;
  logic [63:0]       alpha_lo_q;
  logic [63:0]       alpha_hi_q;
  logic [AlphaW-1:0] alpha;
  logic [SymW-1:0]   sym [NumSyms];
  logic              ok_d;
  logic              ok_q;
  logic              st_valid_q;
  logic [ValueW-1:0] st_value_q;
  logic              advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseLen:   base_q     <= cfg_data_i[BaseW-1:0];
        CfgAlphaLow:  alpha_lo_q <= cfg_data_i;
        CfgAlphaHigh: alpha_hi_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign alpha = {alpha_hi_q, alpha_lo_q};

  // Alphabet check: range, no sign characters, no repeats among the symbols in use
  always_comb begin
    for (int i = 0; i < NumSyms; i++) begin
      sym[i] = alpha[i*SymW +: SymW];
    end
    ok_d = (base_q >= BaseW'(MinBase)) && (base_q <= BaseW'(MaxBase));
    for (int i = 0; i < NumSyms; i++) begin
      if (BaseW'(i) < base_q) begin
        if (sym[i] == PlusChar || sym[i] == MinusChar ||
            sym[i] < SymLow || sym[i] > SymHigh) begin
          ok_d = 1'b0;
        end
        for (int j = i + 1; j < NumSyms; j++) begin
          if (BaseW'(j) < base_q && sym[j] == sym[i]) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  // Items wait in the stage, where the registered check result decides push or drop
  assign advance     = !st_valid_q || !ok_q || !full_i;
  assign in_ready_o  = advance;
  assign push_o      = st_valid_q && ok_q && !full_i;
  assign push_data_o.neg = st_value_q[ValueW-1];
  assign push_data_o.mag = st_value_q[ValueW-1] ? (ValueW'(0) - st_value_q) : st_value_q;
  assign cfg_o.base      = base_q;
  assign cfg_o.alphabet  = alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q       <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
      if (advance) begin
        st_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_value_q <= value_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/itrds_back.sv */
`default_nettype none

module itrds_back import itrds_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     valid_i,
  input  wire q_entry_t data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [7:0]    character_o,
  output logic          last_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv  = 2'd1;
  localparam logic [1:0] SEmit = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [ValueW-1:0]  w_q, w_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               sign_q, sign_d;
  logic [DigCntW-1:0] nd_q, nd_d;
  logic               out_valid_q, out_valid_d;
  logic [SymW-1:0]    char_q, char_d;
  logic               last_q, last_d;
  logic [RemW-1:0]    stack_q [MaxDigits];
  logic [RemW+SliceW-1:0] div_res;
  logic               push_digit;
  logic [DigIdxW-1:0] top_idx;
  logic [RemW-1:0]    top_digit;
  logic               load_out;

  assign div_res   = div_slice(rem_q, w_q[ValueW-1 -: SliceW], cfg_i.base);
  assign top_idx   = DigIdxW'(nd_q - DigCntW'(1));
  assign top_digit = stack_q[top_idx];
  assign load_out  = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == SIdle) && valid_i;

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    rem_d       = rem_q;
    step_d      = step_q;
    sign_d      = sign_q;
    nd_d        = nd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    push_digit  = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (valid_i) begin
          w_d     = data_i.mag;
          sign_d  = data_i.neg;
          rem_d   = '0;
          step_d  = '0;
          nd_d    = '0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        // Digits come out least significant first onto the stack
        w_d    = {w_q[ValueW-SliceW-1:0], div_res[SliceW-1:0]};
        rem_d  = div_res[RemW+SliceW-1:SliceW];
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(StepsPerDigit - 1)) begin
          push_digit = 1'b1;
          nd_d       = nd_q + DigCntW'(1);
          rem_d      = '0;
          if (w_d == '0) begin
            state_d = SEmit;
          end
        end
      end
      SEmit: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            char_d = MinusChar;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = cfg_i.alphabet[{top_digit, 3'b000} +: SymW];
            last_d = (nd_q == DigCntW'(1));
            nd_d   = nd_q - DigCntW'(1);
            if (nd_q == DigCntW'(1)) begin
              state_d = SIdle;
            end
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      nd_q        <= '0;
      sign_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      nd_q        <= nd_d;
      sign_q      <= sign_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
    if (push_digit) begin
      stack_q[nd_q[DigIdxW-1:0]] <= rem_d == '0 ? div_res[RemW+SliceW-1:SliceW] : rem_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* rtl/core/itrds_checker.sv */
`default_nettype none

module itrds_checker import itrds_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] character_o,
  input wire logic       last_o
);

  // A stalled item keeps its character and flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // A sign is always followed by at least one digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == MinusChar |-> !last_o)
    else $error("sign marked as final character");

  // Only printable characters ever leave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> character_o >= SymLow && character_o <= SymHigh)
    else $error("non-printable character emitted");

  // Reset has cleared the output by the next edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind integer_to_radix_digit_stream itrds_checker u_itrds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire
